>>> sv/dvsaed_pkg.sv
// shared types and constants for the address-event decoder
// no dependencies; compile first
package dvsaed_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ADDR_W     = 16;
	localparam int unsigned COORD_W    = 7;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned STAMP_HI_W = 6;
	localparam int unsigned HELD_BYTES = 3;

	// marker bits of the last byte of a frame
	localparam int unsigned WRAP_BIT_IDX  = 7;
	localparam int unsigned RESET_BIT_IDX = 6;
	// address bit that flags a special event
	localparam int unsigned SPECIAL_BIT_IDX = 15;

	localparam logic [TIME_W-1:0] WRAP_STEP = 32'h0000_4000;

	localparam logic [1:0] POS_LAST = 2'd3;

	typedef struct packed {
		logic              last;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] stamp_lo;
	} frame_t;

	typedef struct packed {
		logic               is_special;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic               polarity;
		logic [TIME_W-1:0]  time_us;
	} event_t;

endpackage

>>> sv/dvsaed_if.sv
// valid/ready channel interfaces: raw byte stream in, decoded events out
// depends on nothing; compile after dvsaed_pkg
interface dvsaed_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_transfer;

	modport source (output valid, output data_byte, output first_of_transfer, input ready);
	modport sink   (input valid, input data_byte, input first_of_transfer, output ready);
endinterface

interface dvsaed_event_if;
	logic        valid;
	logic        ready;
	logic        is_special;
	logic [6:0]  pos_x;
	logic [6:0]  pos_y;
	logic        polarity;
	logic [31:0] time_us;

	modport source (output valid, output is_special, output pos_x, output pos_y,
		output polarity, output time_us, input ready);
	modport sink   (input valid, input is_special, input pos_x, input pos_y,
		input polarity, input time_us, output ready);
endinterface

>>> sv/dvsaed_frame_assembler.sv
// frame assembler: tracks byte position in the four-byte frame and holds bytes 0..2
// depends on dvsaed_pkg
module dvsaed_frame_assembler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           data_byte,
	input  logic                 first_of_transfer,
	output dvsaed_pkg::frame_t   frame,
	output logic [1:0]           byte_count
);
	import dvsaed_pkg::*;

	logic [1:0]                          count_q;
	logic [HELD_BYTES-1:0][BYTE_W-1:0]   held_q;
	logic [1:0]                          pos;

	assign pos = first_of_transfer ? 2'd0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (fire) begin
			count_q <= pos + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && pos != POS_LAST) begin
			held_q[pos] <= data_byte;
		end
	end

	always_comb begin
		frame.last     = (pos == POS_LAST);
		frame.addr     = {held_q[1], held_q[0]};
		frame.stamp_lo = held_q[2];
	end

	assign byte_count = count_q;

endmodule

>>> sv/dvsaed_event_builder.sv
// event builder: time base register, marker handling and event field decode
// depends on dvsaed_pkg
module dvsaed_event_builder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           data_byte,
	input  dvsaed_pkg::frame_t   frame,
	output logic                 emit,
	output dvsaed_pkg::event_t   evt
);
	import dvsaed_pkg::*;

	logic [TIME_W-1:0] time_base_q;
	logic              wrap_mark;
	logic              reset_mark;
	logic              special;
	logic [TIME_W-1:0] stamp;

	assign wrap_mark  = data_byte[WRAP_BIT_IDX];
	assign reset_mark = data_byte[RESET_BIT_IDX];
	assign emit       = frame.last && !wrap_mark && !reset_mark;
	assign special    = frame.addr[SPECIAL_BIT_IDX];
	assign stamp      = {{(TIME_W-STAMP_HI_W-BYTE_W){1'b0}},
		data_byte[STAMP_HI_W-1:0], frame.stamp_lo};

	// wrap marker wins over reset marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_base_q <= '0;
		end else if (fire && frame.last) begin
			if (wrap_mark) begin
				time_base_q <= time_base_q + WRAP_STEP;
			end else if (reset_mark) begin
				time_base_q <= '0;
			end
		end
	end

	always_comb begin
		evt.is_special = special;
		if (special) begin
			evt.pos_x    = '0;
			evt.pos_y    = '0;
			evt.polarity = 1'b0;
			evt.time_us  = '0;
		end else begin
			evt.pos_x    = frame.addr[COORD_W:1];
			evt.pos_y    = frame.addr[2*COORD_W:BYTE_W];
			evt.polarity = ~frame.addr[0];
			evt.time_us  = time_base_q + stamp;
		end
	end

endmodule

>>> sv/dvs_address_event_decoder.sv
// top level of the address-event decoder: input register, frame assembly,
// event decode and result register; depends on dvsaed_pkg, dvsaed_if and submodules
//
//   channel  | dir | fields                                          | role
//   ---------+-----+-------------------------------------------------+-----------------------
//   raw      | in  | data_byte[7:0], first_of_transfer               | sensor byte stream
//   events   | out | is_special, pos_x[6:0], pos_y[6:0], polarity,   | decoded events,
//            |     | time_us[31:0]                                   | at most one per frame
//
// one byte is taken every cycle unless a byte that closes an event frame waits for the
// result register; a byte passes the input register and then the decode logic, and an
// event is loaded into the result register when the fourth byte of its frame moves on
// the result register frees the input side: a new byte is taken while an event
// waits, and only a stalled event blocks the next frame-closing byte
// reset clears frame position, time base and the valid flags of both registers
module dvs_address_event_decoder (
	input  logic               clk,
	input  logic               arst_n,
	dvsaed_byte_if.sink        raw,
	dvsaed_event_if.source     events
);
	import dvsaed_pkg::*;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;

	// result register
	logic   out_valid_q;
	event_t out_q;

	// decode
	frame_t     frame;
	event_t     evt;
	logic       emit;
	logic       out_free;
	logic       adv_s1;
	logic [1:0] byte_count;

	// a byte leaves the input register unless it closes an event frame and
	// the result register is still occupied
	assign out_free  = !out_valid_q || events.ready;
	assign adv_s1    = valid_s1 && (!emit || out_free);
	assign raw.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1  <= raw.data_byte;
			first_s1 <= raw.first_of_transfer;
		end
	end

	dvsaed_frame_assembler u_frame (
		.clk               (clk),
		.arst_n            (arst_n),
		.fire              (adv_s1),
		.data_byte         (byte_s1),
		.first_of_transfer (first_s1),
		.frame             (frame),
		.byte_count        (byte_count)
	);

	dvsaed_event_builder u_event (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv_s1),
		.data_byte (byte_s1),
		.frame     (frame),
		.emit      (emit),
		.evt       (evt)
	);

	// result register: loaded by a frame-closing byte that carries no marker, emptied by the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			out_q <= evt;
		end
	end

	assign events.valid      = out_valid_q;
	assign events.is_special = out_q.is_special;
	assign events.pos_x      = out_q.pos_x;
	assign events.pos_y      = out_q.pos_y;
	assign events.polarity   = out_q.polarity;
	assign events.time_us    = out_q.time_us;

	// a held byte stays in the input register until it can move on
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a stalled item");

	// a restart flag puts the next byte at frame position one
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && first_s1 |=> byte_count == 2'd1)
		else $error("frame position not restarted");

	// a new event appears only after a frame-closing byte was decoded
	a_event_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && emit && frame.last))
		else $error("event without a closing byte");

	// an event never overwrites one that the sink has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !events.ready |-> !(adv_s1 && emit))
		else $error("pending event overwritten");

endmodule
